// ----- rtl/qmce_pkg.sv -----
// Shared constants, operation codes and control structs of the measurement and collapse engine.
package qmce_pkg;

  localparam int AMP_W              = 16;
  localparam int WORD_W             = 2 * AMP_W;
  localparam int IDX_W              = 10;
  localparam int TGT_W              = 4;
  localparam int SCALE_W            = 24;
  localparam int PROB_W             = 31;
  localparam int QCFG_W             = 4;
  localparam int NQ_W               = 5;
  localparam int MAX_QUBITS_DEFAULT = 10;

  localparam logic [QCFG_W-1:0] QUBITS_RESET = QCFG_W'(10);
  localparam logic [PROB_W-1:0] PROB_MAX     = {PROB_W{1'b1}};
  localparam logic [AMP_W-1:0]  AMP_ZERO     = '0;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_READ     = 2'd1,
    OP_MEASURE  = 2'd2,
    OP_COLLAPSE = 2'd3
  } op_t;

  // Settings that hold for a whole sweep over the state vector.
  typedef struct packed {
    logic               collapse;
    logic               zero_group;
    logic [SCALE_W-1:0] factor;
  } sweep_cmd_t;

  // Tag that travels alongside one memory read of a sweep.
  typedef struct packed {
    logic valid;
    logic grp;
  } sweep_tap_t;

endpackage

// ----- rtl/qmce_amp_ram.sv -----
// Amplitude memory: one write port and one read port with registered read data.
module qmce_amp_ram import qmce_pkg::*; #(
  parameter int AW = MAX_QUBITS_DEFAULT,
  parameter int DW = WORD_W
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/qmce_sweep_alu.sv -----
// Sweep datapath: squares and sums for a measurement, scaled write-back for a collapse.
module qmce_sweep_alu import qmce_pkg::*; #(
  parameter int AW = MAX_QUBITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  sweep_cmd_t        cmd,
  input  sweep_tap_t        tap,
  input  logic [AW-1:0]     tap_addr,
  input  logic [WORD_W-1:0] rd_data,
  output logic              wb_en,
  output logic [AW-1:0]     wb_addr,
  output logic [WORD_W-1:0] wb_data,
  output logic [PROB_W-1:0] acc0,
  output logic [PROB_W-1:0] acc1
);

  localparam int OPB_W = SCALE_W + 1;
  localparam int MUL_W = AMP_W + 1 + OPB_W;

  // Adds the rounding half, takes the Q1.15 by Q8.16 product back to Q1.15 and saturates.
  function automatic logic [AMP_W-1:0] round_sat(input logic signed [MUL_W-1:0] p);
    logic signed [MUL_W-1:0]  t;
    logic signed [MUL_W-17:0] q;
    t = p + MUL_W'(32768);
    q = (MUL_W-16)'(t >>> 16);
    if (q > (MUL_W-16)'(32767)) begin
      return {1'b0, {(AMP_W-1){1'b1}}};
    end else if (q < -(MUL_W-16)'(32768)) begin
      return {1'b1, {(AMP_W-1){1'b0}}};
    end else begin
      return q[AMP_W-1:0];
    end
  endfunction

  logic signed [AMP_W-1:0] re;
  logic signed [AMP_W-1:0] im;
  logic signed [OPB_W-1:0] opb_re;
  logic signed [OPB_W-1:0] opb_im;

  logic                    v2;
  logic                    grp2;
  logic                    kill2;
  logic [AW-1:0]           addr2;
  logic signed [MUL_W-1:0] mul_re;
  logic signed [MUL_W-1:0] mul_im;

  logic [PROB_W:0]   mag;
  logic [PROB_W+1:0] sum0;
  logic [PROB_W+1:0] sum1;

  assign re = $signed(rd_data[AMP_W-1:0]);
  assign im = $signed(rd_data[WORD_W-1:AMP_W]);

  // A collapse multiplies by the factor, a measurement squares each part.
  always_comb begin
    if (cmd.collapse) begin
      opb_re = $signed({1'b0, cmd.factor});
      opb_im = $signed({1'b0, cmd.factor});
    end else begin
      opb_re = OPB_W'(re);
      opb_im = OPB_W'(im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= tap.valid;
    end
    grp2   <= tap.grp;
    kill2  <= (tap.grp == cmd.zero_group);
    addr2  <= tap_addr;
    mul_re <= MUL_W'(re) * MUL_W'(opb_re);
    mul_im <= MUL_W'(im) * MUL_W'(opb_im);
  end

  assign wb_en   = v2 && cmd.collapse;
  assign wb_addr = addr2;
  assign wb_data = kill2 ? {AMP_ZERO, AMP_ZERO} : {round_sat(mul_im), round_sat(mul_re)};

  // Each square is at most 2^30, so both fit in the low bits.
  assign mag  = {1'b0, mul_re[PROB_W-1:0]} + {1'b0, mul_im[PROB_W-1:0]};
  assign sum0 = {2'b00, acc0} + {1'b0, mag};
  assign sum1 = {2'b00, acc1} + {1'b0, mag};

  always_ff @(posedge clk) begin
    if (clear) begin
      acc0 <= '0;
      acc1 <= '0;
    end else if (v2 && !cmd.collapse) begin
      if (grp2) begin
        acc1 <= (sum1 > {2'b00, PROB_MAX}) ? PROB_MAX : sum1[PROB_W-1:0];
      end else begin
        acc0 <= (sum0 > {2'b00, PROB_MAX}) ? PROB_MAX : sum0[PROB_W-1:0];
      end
    end
  end

endmodule

// ----- rtl/qubit_measure_collapse_engine_top.sv -----
// Top level of the qubit measurement and collapse engine: control, configuration and ports.
// One request is in work at a time; the sweep visits one amplitude a cycle through the single
// read port of the amplitude memory, with write-back after the read data and product registers.
// Reset sets qubits_in_use to 10 and clears the control state; the amplitude memory is not
// cleared and holds no meaningful data until written.
module qubit_measure_collapse_engine_top import qmce_pkg::*; #(
  parameter int MAX_QUBITS = MAX_QUBITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [QCFG_W-1:0] cfg_data,     // qubits_in_use
  input  logic              s_tvalid,
  output logic              s_tready,
  // basis_index[9:0], amp_real_in[25:10], amp_imag_in[41:26], target_qubit[45:42],
  // zero_group[46], scale_factor[70:47], zero pad[71]
  input  logic [71:0]       s_tdata,
  input  logic [1:0]        s_tuser,      // operation[1:0]
  output logic              m_tvalid,
  input  logic              m_tready,
  // amp_real_out[15:0], amp_imag_out[31:16], prob_bit_zero[62:32], prob_bit_one[93:63],
  // zero pad[95:94]
  output logic [95:0]       m_tdata,
  output logic              m_tuser       // status
);

  localparam int AW = MAX_QUBITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Request fields.
  op_t                in_op;
  logic [IDX_W-1:0]   in_basis;
  logic [AMP_W-1:0]   in_re;
  logic [AMP_W-1:0]   in_im;
  logic [TGT_W-1:0]   in_tgt;
  logic               in_zg;
  logic [SCALE_W-1:0] in_factor;

  assign in_op     = op_t'(s_tuser);
  assign in_basis  = s_tdata[9:0];
  assign in_re     = s_tdata[25:10];
  assign in_im     = s_tdata[41:26];
  assign in_tgt    = s_tdata[45:42];
  assign in_zg     = s_tdata[46];
  assign in_factor = s_tdata[70:47];

  // The configuration register is written only while the engine is idle.
  logic [QCFG_W-1:0] qubits_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      qubits_in_use <= QUBITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      qubits_in_use <= cfg_data;
    end
  end

  // A register value of zero acts as one qubit, and anything above the storage acts as full size.
  logic [NQ_W-1:0] n_act;
  logic            idx_bad;
  logic            tgt_bad;
  logic [AW-1:0]   last_addr;

  always_comb begin
    if (qubits_in_use == '0) begin
      n_act = NQ_W'(1);
    end else if (NQ_W'(qubits_in_use) > NQ_W'(MAX_QUBITS)) begin
      n_act = NQ_W'(MAX_QUBITS);
    end else begin
      n_act = NQ_W'(qubits_in_use);
    end
  end

  assign idx_bad   = (32'(in_basis) >> n_act) != 32'd0;
  assign tgt_bad   = NQ_W'(in_tgt) >= n_act;
  assign last_addr = AW'((32'd1 << n_act) - 32'd1);

  // Control state.
  state_t      state;
  op_t         op_r;
  sweep_cmd_t  cmd;
  logic [TGT_W-1:0] tgt_r;
  logic [AW-1:0]    cnt;
  logic             drain;
  logic             res_status;
  logic [AMP_W-1:0] res_re;
  logic [AMP_W-1:0] res_im;
  sweep_tap_t       tap1;
  logic [AW-1:0]    addr1;

  // Output register.
  logic [AMP_W-1:0]  out_re;
  logic [AMP_W-1:0]  out_im;
  logic [PROB_W-1:0] out_p0;
  logic [PROB_W-1:0] out_p1;
  logic              out_status;

  // A configuration write takes precedence over a request in the idle state, so every request
  // sees a settled qubit count.
  logic accept;
  assign cfg_ready = (state == ST_IDLE);
  assign s_tready  = (state == ST_IDLE) && !cfg_valid;
  assign accept    = s_tvalid && s_tready;

  // Memory and sweep datapath.
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;
  logic              wb_en;
  logic [AW-1:0]     wb_addr;
  logic [WORD_W-1:0] wb_data;
  logic [PROB_W-1:0] acc0;
  logic [PROB_W-1:0] acc1;

  // A single write request and the collapse write-back never overlap, since a request is only
  // taken in the idle state and the write-back runs only during a sweep and its drain.
  assign ram_rd_en   = (accept && in_op == OP_READ && !idx_bad) || (state == ST_SWEEP);
  assign ram_rd_addr = (state == ST_SWEEP) ? cnt : AW'(in_basis);
  assign ram_wr_en   = (accept && in_op == OP_WRITE && !idx_bad) || wb_en;
  assign ram_wr_addr = wb_en ? wb_addr : AW'(in_basis);
  assign ram_wr_data = wb_en ? wb_data : {in_im, in_re};

  qmce_amp_ram #(
    .AW (AW),
    .DW (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // The sweep's read addresses rise by one each cycle and the write-back trails them through the
  // registered read data and product, so a read never meets a pending write to the same amplitude.
  qmce_sweep_alu #(
    .AW (AW)
  ) u_alu (
    .clk      (clk),
    .rst      (rst),
    .clear    (accept),
    .cmd      (cmd),
    .tap      (tap1),
    .tap_addr (addr1),
    .rd_data  (ram_rd_data),
    .wb_en    (wb_en),
    .wb_addr  (wb_addr),
    .wb_data  (wb_data),
    .acc0     (acc0),
    .acc1     (acc1)
  );

  // Tag each sweep read with its group, the target bit of its address.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap1.valid <= 1'b0;
    end else begin
      tap1.valid <= (state == ST_SWEEP);
    end
    tap1.grp <= 1'(cnt >> tgt_r);
    addr1    <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // The output register fills when a result is finished and empties when it is taken.
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_r           <= in_op;
            tgt_r          <= in_tgt;
            cmd.collapse   <= (in_op == OP_COLLAPSE);
            cmd.zero_group <= in_zg;
            cmd.factor     <= in_factor;
            cnt            <= '0;
            drain          <= 1'b0;
            res_re         <= AMP_ZERO;
            res_im         <= AMP_ZERO;
            case (in_op)
              OP_WRITE, OP_READ: begin
                res_status <= idx_bad;
                state      <= (in_op == OP_READ && !idx_bad) ? ST_RD_WAIT : ST_DONE;
              end
              default: begin
                res_status <= tgt_bad;
                state      <= tgt_bad ? ST_DONE : ST_SWEEP;
              end
            endcase
          end
        end
        ST_RD_WAIT: begin
          res_re <= ram_rd_data[AMP_W-1:0];
          res_im <= ram_rd_data[WORD_W-1:AMP_W];
          state  <= ST_DONE;
        end
        ST_SWEEP: begin
          cnt <= cnt + AW'(1);
          if (cnt == last_addr) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // The drain lets the last read pass the datapath and reach the sums or the memory.
          drain <= 1'b1;
          if (drain) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_re     <= res_re;
            out_im     <= res_im;
            out_status <= res_status;
            if (op_r == OP_MEASURE && !res_status) begin
              out_p0 <= acc0;
              out_p1 <= acc1;
            end else begin
              out_p0 <= '0;
              out_p1 <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {2'b00, out_p1, out_p0, out_im, out_re};
  assign m_tuser = out_status;

endmodule

// ----- tb/qmce_checker.sv -----
// Checker for the measurement and collapse engine: predicts each result and compares it.
module qmce_checker import qmce_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [QCFG_W-1:0] cfg_data,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [71:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [95:0]       m_tdata,
  input  logic              m_tuser,
  output int                failures,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [AMP_W-1:0]  re;
    logic [AMP_W-1:0]  im;
    logic [PROB_W-1:0] p0;
    logic [PROB_W-1:0] p1;
    logic              status;
  } outcome_t;

  outcome_t         expected_outcomes[$];
  logic [AMP_W-1:0] re_store[1 << MAX_QUBITS_DEFAULT];
  logic [AMP_W-1:0] im_store[1 << MAX_QUBITS_DEFAULT];
  logic [QCFG_W-1:0] qubits_reg;

  function automatic int active_qubits(input logic [QCFG_W-1:0] setting);
    int n;
    n = int'(setting);
    if (n < 1) n = 1;
    if (n > MAX_QUBITS_DEFAULT) n = MAX_QUBITS_DEFAULT;
    return n;
  endfunction

  // Q1.15 times unsigned Q8.16, rounded half up, saturated back to Q1.15.
  function automatic logic [AMP_W-1:0] rescale(input logic [AMP_W-1:0] a,
                                               input logic [SCALE_W-1:0] factor);
    longint prod;
    longint q;
    prod = longint'($signed(a)) * longint'(factor) + 64'sd32768;
    q = prod >>> 16;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[AMP_W-1:0];
  endfunction

  function automatic longint clip_prob(input longint sum);
    return (sum > longint'(PROB_MAX)) ? longint'(PROB_MAX) : sum;
  endfunction

  // Applies one request to the mirrored state vector and returns its result.
  function automatic outcome_t apply_request(input op_t op, input logic [71:0] data);
    outcome_t          res;
    logic [IDX_W-1:0]  idx;
    logic [TGT_W-1:0]  tgt;
    logic              zg;
    logic [SCALE_W-1:0] factor;
    int                n;
    int                len;
    longint            sum0;
    longint            sum1;
    longint            mag;
    idx    = data[9:0];
    tgt    = data[45:42];
    zg     = data[46];
    factor = data[70:47];
    n      = active_qubits(qubits_reg);
    len    = 1 << n;
    res    = '0;
    sum0   = 0;
    sum1   = 0;
    if (op == OP_WRITE || op == OP_READ) begin
      if (int'(idx) >= len) begin
        res.status = 1'b1;
      end else if (op == OP_WRITE) begin
        re_store[idx] = data[25:10];
        im_store[idx] = data[41:26];
      end else begin
        res.re = re_store[idx];
        res.im = im_store[idx];
      end
    end else if (int'(tgt) >= n) begin
      res.status = 1'b1;
    end else if (op == OP_MEASURE) begin
      for (int i = 0; i < len; i++) begin
        mag = longint'($signed(re_store[i])) * longint'($signed(re_store[i]))
            + longint'($signed(im_store[i])) * longint'($signed(im_store[i]));
        if ((i >> tgt) & 1) sum1 += mag;
        else sum0 += mag;
      end
      res.p0 = PROB_W'(clip_prob(sum0));
      res.p1 = PROB_W'(clip_prob(sum1));
    end else begin
      for (int i = 0; i < len; i++) begin
        if (((i >> tgt) & 1) == int'(zg)) begin
          re_store[i] = AMP_ZERO;
          im_store[i] = AMP_ZERO;
        end else begin
          re_store[i] = rescale(re_store[i], factor);
          im_store[i] = rescale(im_store[i], factor);
        end
      end
    end
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    if (failures < 10) $display("%s", msg);
    failures++;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      qubits_reg = QUBITS_RESET;
      expected_outcomes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[31:16], m_tdata[62:32], m_tdata[93:63], m_tuser};
        if (expected_outcomes.size() == 0) begin
          note_failure($sformatf("unexpected result at %0t: data %h status %b",
                                 $realtime, m_tdata, m_tuser));
        end else begin
          want = expected_outcomes.pop_front();
          if (got != want || m_tdata[95:94] != 2'b00) begin
            note_failure($sformatf(
              "result mismatch at %0t: expected re %0d im %0d p0 %0d p1 %0d st %b, got re %0d im %0d p0 %0d p1 %0d st %b pad %b",
              $realtime, $signed(want.re), $signed(want.im), want.p0, want.p1, want.status,
              $signed(got.re), $signed(got.im), got.p0, got.p1, got.status, m_tdata[95:94]));
          end
        end
      end
      if (cfg_valid && cfg_ready) qubits_reg = cfg_data;
      if (s_tvalid && s_tready) expected_outcomes.push_back(apply_request(op_t'(s_tuser), s_tdata));
    end
    pending = expected_outcomes.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the engine testbench: clock, reset, request stimulus, result acceptance and verdict.
module testbench import qmce_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any handshake before the run is declared hung. The slowest legal gap is
  // a ten-qubit sweep stacked on the long result hold-off.
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [QCFG_W-1:0] cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  // basis_index[9:0], amp_real_in[25:10], amp_imag_in[41:26], target_qubit[45:42],
  // zero_group[46], scale_factor[70:47], zero pad[71]
  logic [71:0]       s_tdata;
  logic [1:0]        s_tuser;      // operation[1:0]
  logic              m_tvalid;
  logic              m_tready;
  // amp_real_out[15:0], amp_imag_out[31:16], prob_bit_zero[62:32], prob_bit_one[93:63],
  // zero pad[95:94]
  logic [95:0]       m_tdata;
  logic              m_tuser;      // status

  int failures;
  int pending;
  int quiet_cycles;

  // Stimulus-side view of the state vector: which entries hold a written amplitude, and how
  // many qubits the engine currently simulates. Reads and sweeps only ever touch written
  // entries, since the amplitude memory is not cleared at reset.
  bit written[1 << MAX_QUBITS_DEFAULT];
  int active_n;

  // Random idling on both sides; cleared for a calm stretch. The receiver hold-off is
  // requested by the stimulus and carried out, and marked done, by the receiver process.
  bit idling;
  bit stall_go;
  bit stall_done;

  qubit_measure_collapse_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  qmce_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a run that stops moving on every channel for too long has hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side. Accepts results with random back-pressure, and once asked holds ready low
  // for a long stretch so that the engine stalls and backs up its request side.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_go && !stall_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        stall_done = 1'b1;
      end else begin
        m_tready <= !(idling && $urandom_range(99) < 23);
        @(negedge clk);
      end
    end
  end

  // Amplitudes: mostly random with a random magnitude, so that measure sums land both below
  // and above saturation, plus the two extremes of Q1.15.
  function automatic logic [AMP_W-1:0] random_amp();
    logic signed [AMP_W-1:0] v;
    v = AMP_W'($urandom);
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return v >>> $urandom_range(8);
    endcase
  endfunction

  // Offers one request at the falling edge and returns at the falling edge after it was
  // taken. Valid stays high from one request to the next unless a random gap is drawn.
  task automatic send_request(input op_t op, input logic [IDX_W-1:0] idx,
                              input logic [AMP_W-1:0] re, input logic [AMP_W-1:0] im,
                              input logic [TGT_W-1:0] tgt, input logic zg,
                              input logic [SCALE_W-1:0] factor);
    while (idling && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tuser  <= op;
    s_tdata  <= {1'b0, factor, zg, tgt, im, re, idx};
    s_tvalid <= 1'b1;
    if (op == OP_WRITE && int'(idx) < (1 << active_n)) written[idx] = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender pause: nothing more is offered until every expected result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes the qubit count while the engine is idle, then loads every entry of the new
  // vector length that was never written, with random amplitudes.
  task automatic enter_phase(input logic [QCFG_W-1:0] setting);
    drain_results();
    cfg_data  <= setting;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (setting == 0) active_n = 1;
    else if (int'(setting) > MAX_QUBITS_DEFAULT) active_n = MAX_QUBITS_DEFAULT;
    else active_n = int'(setting);
    for (int i = 0; i < (1 << active_n); i++) begin
      if (!written[i]) begin
        send_request(OP_WRITE, IDX_W'(i), random_amp(), random_amp(), TGT_W'($urandom),
                     1'($urandom), SCALE_W'($urandom));
      end
    end
  endtask

  // One random request with random content in every field. A small share carries an index
  // or target beyond the qubits in use, which the engine must flag without any change.
  task automatic random_request();
    int                 len;
    int                 roll;
    bit                 noise;
    logic [IDX_W-1:0]   idx;
    logic [TGT_W-1:0]   tgt;
    logic [SCALE_W-1:0] factor;
    op_t                op;
    len   = 1 << active_n;
    roll  = $urandom_range(99);
    noise = ($urandom_range(99) < 8);
    if (noise && len < (1 << IDX_W)) idx = IDX_W'($urandom_range((1 << IDX_W) - 1, len));
    else idx = IDX_W'($urandom_range(len - 1));
    if (noise) tgt = TGT_W'($urandom_range((1 << TGT_W) - 1, active_n));
    else tgt = TGT_W'($urandom_range(active_n - 1));
    // Scale factors cluster around one so that repeated collapses keep the vector alive.
    case ($urandom_range(5))
      0:       factor = '0;
      1:       factor = '1;
      2:       factor = SCALE_W'($urandom);
      default: factor = SCALE_W'(32'h10000 + $urandom_range(16384) - 8192);
    endcase
    if (roll < 35) op = OP_WRITE;
    else if (roll < 65) op = OP_READ;
    else if (roll < 82) op = OP_MEASURE;
    else op = OP_COLLAPSE;
    if (op == OP_MEASURE || op == OP_COLLAPSE) idx = IDX_W'($urandom);
    else tgt = TGT_W'($urandom);
    send_request(op, idx, random_amp(), random_amp(), tgt, 1'($urandom), factor);
  endtask

  // Qubit settings for the random part: the out-of-range values zero (acts as one) and
  // twelve and fifteen (act as ten) sit among in-range ones. Ten comes late, since the full
  // vector has to be loaded before it can be swept.
  logic [QCFG_W-1:0] phase_settings[10] = '{4'd1, 4'd3, 4'd0, 4'd5, 4'd2, 4'd7, 4'd4,
                                            4'd10, 4'd15, 4'd12};
  int                phase_items[10]    = '{8, 8, 8, 8, 8, 8, 8, 10, 6, 6};

  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    idling     = 1'b1;
    stall_go   = 1'b0;
    stall_done = 1'b0;
    active_n   = MAX_QUBITS_DEFAULT;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part on a two-qubit vector.
    enter_phase(4'd2);
    send_request(OP_WRITE, 10'd0, 16'h7FFF, 16'h8000, '0, 1'b0, '0);
    send_request(OP_WRITE, 10'd1, 16'h8000, 16'h8000, '0, 1'b0, '0);
    send_request(OP_WRITE, 10'd2, 16'h0000, 16'h0000, '0, 1'b0, '0);
    send_request(OP_WRITE, 10'd3, 16'h0001, 16'hFFFF, '0, 1'b0, '0);
    send_request(OP_READ, 10'd1, '0, '0, '0, 1'b0, '0);
    send_request(OP_READ, 10'd3, '0, '0, '0, 1'b0, '0);
    // Index beyond the vector for a write and for a read: flagged, nothing stored.
    send_request(OP_WRITE, 10'd4, 16'h1234, 16'h4321, '0, 1'b0, '0);
    send_request(OP_READ, 10'd1023, '0, '0, '0, 1'b0, '0);
    // Full-scale entries: the bit-one, then bit-zero group exceeds Q1.30 and saturates.
    send_request(OP_MEASURE, '0, '0, '0, 4'd0, 1'b0, '0);
    send_request(OP_MEASURE, '0, '0, '0, 4'd1, 1'b0, '0);
    // Targets beyond the qubits in use, the nearest and the farthest.
    send_request(OP_MEASURE, '0, '0, '0, 4'd2, 1'b0, '0);
    send_request(OP_MEASURE, '0, '0, '0, 4'd15, 1'b0, '0);
    // Halving odd values: plus one half rounds up, minus one half rounds up to zero.
    send_request(OP_COLLAPSE, '0, '0, '0, 4'd1, 1'b0, 24'h008000);
    send_request(OP_READ, 10'd3, '0, '0, '0, 1'b0, '0);
    send_request(OP_READ, 10'd2, '0, '0, '0, 1'b0, '0);
    // Largest factor saturates both ways; then a zero-factor collapse zeroes the survivors' group.
    send_request(OP_WRITE, 10'd0, 16'h4000, 16'hC000, '0, 1'b0, '0);
    send_request(OP_COLLAPSE, '0, '0, '0, 4'd0, 1'b1, 24'hFFFFFF);
    send_request(OP_READ, 10'd0, '0, '0, '0, 1'b0, '0);
    send_request(OP_COLLAPSE, '0, '0, '0, 4'd0, 1'b0, 24'h000000);
    send_request(OP_COLLAPSE, '0, '0, '0, 4'd3, 1'b1, 24'h010000);
    send_request(OP_MEASURE, '0, '0, '0, 4'd0, 1'b0, '0);

    // Random part, one qubit setting per phase. The five-qubit phase starts the long result
    // hold-off; the seven-qubit phase, its vector load included, runs with no idling on
    // either side.
    for (int p = 0; p < 10; p++) begin
      idling = (phase_settings[p] != 4'd7);
      enter_phase(phase_settings[p]);
      if (phase_settings[p] == 4'd5) stall_go = 1'b1;
      for (int k = 0; k < phase_items[p]; k++) random_request();
    end
    idling = 1'b1;

    drain_results();
    repeat (50) @(negedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
